@@ rtl/smr_pkg.sv @@
package smr_pkg;

    localparam int TIME_W  = 32;
    localparam int RATE_W  = 24;
    localparam int SPEED_W = 8;
    localparam int LEVEL_W = 8;
    localparam int MODE_W  = 2;

    // item kinds carried on tuser
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GOAL128 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GOAL28  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ESTOP   = 2'd3;

    // configuration register indexes
    localparam logic CFG_ACCEL = 1'b0;
    localparam logic CFG_DECEL = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ rtl/smr_div.sv @@
module smr_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  smr_pkg::t_div_ctl               i_ctl,
    input  logic [smr_pkg::TIME_W-1:0]      i_dividend,
    input  logic [smr_pkg::RATE_W-1:0]      i_divisor,
    output smr_pkg::t_div_sts               o_sts,
    output logic [smr_pkg::TIME_W-1:0]      o_quotient
);

    localparam int TW    = smr_pkg::TIME_W;
    localparam int RW    = smr_pkg::RATE_W;
    localparam int CNT_W = $clog2(TW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TW - 1);

    logic [RW:0]      r_rem, n_rem;
    logic [TW-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [RW:0]      shifted;
    logic [RW:0]      diff;

    // one restoring-division step per cycle, quotient bits enter from the right
    assign shifted = {r_rem[RW-1:0], r_quo[TW-1]};
    assign diff    = shifted - {1'b0, i_divisor};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start && !r_busy) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[RW]) begin
                n_rem = diff;
                n_quo = {r_quo[TW-2:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[TW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/speed_momentum_ramp.sv @@
// Speed ramp with momentum for a motor drive.
// Input stream (s_axis): tuser carries the item kind (tick, 128-step goal,
// 28-step goal, emergency stop); tdata carries speed value, timestamp and
// the two drive levels. Output stream (m_axis) returns exactly one result per
// input item: current speed, direction and the drive level for it.
// Configuration: i_cfg_we writes i_cfg_wdata into accel (index 0) or decel
// (index 1) rate; write only while the block holds no item.
// Every item passes the execute and done states before its result is
// registered; a tick that must move the speed with a nonzero rate also
// runs the restoring divider (one quotient bit per cycle) between them.
// One item is processed at a time; s_axis_tready is low until its result
// is registered, so no new item is taken before then.
// A new item may be accepted while the previous result still waits.
// Reset: goal and current speed go to forward stop (+1), the time
// accumulator, last timestamp and both rates clear.
// Stall: a stalled output holds its result; the next result waits in the
// final state until the output register frees up.
module speed_momentum_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] speed_value, [39:8] now_us, [47:40] forward_level,
    // [55:48] reverse_level
    input  logic [55:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] current_speed, [8] reverse, [16:9] drive_level, [23:17] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);

    localparam int TW = smr_pkg::TIME_W;
    localparam int RW = smr_pkg::RATE_W;
    localparam int SW = smr_pkg::SPEED_W;
    localparam int LW = smr_pkg::LEVEL_W;
    localparam int AW = SW + 2;  // room for speed +/- 255 steps

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic signed [SW-1:0] SPD_FWD = SW'(1);
    localparam logic signed [SW-1:0] SPD_REV = -SW'(1);

    logic [2:0] r_state, n_state;

    logic [RW-1:0]          r_accel, r_decel;
    logic signed [SW-1:0]   r_goal, n_goal;
    logic signed [SW-1:0]   r_pres, n_pres;
    logic [TW-1:0]          r_accum, n_accum;
    logic [TW-1:0]          r_last, n_last;
    logic [RW-1:0]          r_rate, n_rate;

    logic [smr_pkg::MODE_W-1:0] r_mode;
    logic signed [SW-1:0]   r_sv;
    logic [TW-1:0]          r_now;
    logic [LW-1:0]          r_fwd_lvl, r_rev_lvl;

    logic                   r_out_valid, n_out_valid;
    logic signed [SW-1:0]   r_out_speed;
    logic                   r_out_rev;
    logic [LW-1:0]          r_out_lvl;

    smr_pkg::t_div_ctl      div_ctl;
    smr_pkg::t_div_sts      div_sts;
    logic [TW-1:0]          div_quo;

    logic                   in_fire;
    logic                   out_free;
    logic [TW-1:0]          delta;
    logic [TW:0]            accum_sum;
    logic [SW-1:0]          mag;
    logic [SW-1:0]          mag_m1;
    logic [SW+2:0]          mag_x9;
    logic [SW+1:0]          scaled;
    logic [SW-2:0]          scaled_sat;
    logic signed [SW-1:0]   goal28;
    logic [SW-1:0]          steps;
    logic signed [AW-1:0]   pres_w, goal_w, up_w, dn_w;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // 28-step goal: ((|n| - 1) * 9) >> 1, magnitude 0 taken as 1, cap at 127
    assign mag        = r_sv[SW-1] ? SW'(-r_sv) : SW'(r_sv);
    assign mag_m1     = (mag == '0) ? '0 : mag - 1'b1;
    assign mag_x9     = {mag_m1, 3'b000} + {3'b000, mag_m1};
    assign scaled     = mag_x9[SW+2:1];
    assign scaled_sat = (scaled > (SW+2)'(2**(SW-1) - 1)) ? '1 : scaled[SW-2:0];
    assign goal28     = r_sv[SW-1] ? -$signed({1'b0, scaled_sat})
                                   : $signed({1'b0, scaled_sat});

    assign delta     = r_now - r_last;
    assign accum_sum = {1'b0, r_accum} + {1'b0, delta};

    assign steps  = (div_quo[TW-1:SW] != '0) ? '1 : div_quo[SW-1:0];
    assign pres_w = AW'(r_pres);
    assign goal_w = AW'(r_goal);
    assign up_w   = pres_w + $signed({2'b00, steps});
    assign dn_w   = pres_w - $signed({2'b00, steps});

    assign div_ctl.start = (r_state == S_DIVGO);

    smr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_accum),
        .i_divisor  (r_rate),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_goal      = r_goal;
        n_pres      = r_pres;
        n_accum     = r_accum;
        n_last      = r_last;
        n_rate      = r_rate;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_mode)
                    smr_pkg::MODE_TICK: begin
                        n_last = r_now;
                        if (r_goal == r_pres) begin
                            n_accum = '0;
                        end else begin
                            if (r_pres > r_goal) begin
                                n_rate = r_pres[SW-1] ? r_accel : r_decel;
                            end else begin
                                n_rate = (r_pres > 0) ? r_accel : r_decel;
                            end
                            if (n_rate == '0) begin
                                // instant jump, stop crossing snaps to other stop
                                if (r_pres < SPD_REV && r_goal > SPD_REV) begin
                                    n_pres = SPD_FWD;
                                end else if (r_pres > SPD_FWD && r_goal < SPD_FWD) begin
                                    n_pres = SPD_REV;
                                end else begin
                                    n_pres = r_goal;
                                end
                            end else begin
                                n_accum = accum_sum[TW] ? smr_pkg::TIME_MAX
                                                        : accum_sum[TW-1:0];
                                n_state = S_DIVGO;
                            end
                        end
                    end
                    smr_pkg::MODE_GOAL128: begin
                        n_goal = r_sv;
                    end
                    smr_pkg::MODE_GOAL28: begin
                        n_goal = goal28;
                    end
                    smr_pkg::MODE_ESTOP: begin
                        n_goal = r_sv[SW-1] ? SPD_REV : SPD_FWD;
                        n_pres = r_sv[SW-1] ? SPD_REV : SPD_FWD;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIVGO: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_DONE;
                if (div_quo != '0) begin
                    n_accum = '0;
                    if (r_goal > r_pres) begin
                        if (r_pres[SW-1] && !up_w[AW-1]) begin
                            n_pres = SPD_FWD;
                        end else if (up_w >= goal_w) begin
                            n_pres = r_goal;
                        end else begin
                            n_pres = up_w[SW-1:0];
                        end
                    end else begin
                        if (r_pres > 0 && dn_w <= 0) begin
                            n_pres = SPD_REV;
                        end else if (dn_w <= goal_w) begin
                            n_pres = r_goal;
                        end else begin
                            n_pres = dn_w[SW-1:0];
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_goal      <= SPD_FWD;
            r_pres      <= SPD_FWD;
            r_accum     <= '0;
            r_last      <= '0;
            r_accel     <= '0;
            r_decel     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_goal      <= n_goal;
            r_pres      <= n_pres;
            r_accum     <= n_accum;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    smr_pkg::CFG_ACCEL: r_accel <= i_cfg_wdata;
                    smr_pkg::CFG_DECEL: r_decel <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate <= n_rate;
        if (in_fire) begin
            r_mode    <= s_axis_tuser;
            r_sv      <= s_axis_tdata[7:0];
            r_now     <= s_axis_tdata[39:8];
            r_fwd_lvl <= s_axis_tdata[47:40];
            r_rev_lvl <= s_axis_tdata[55:48];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_speed <= r_pres;
            r_out_rev   <= r_pres[SW-1];
            r_out_lvl   <= r_pres[SW-1] ? r_rev_lvl : r_fwd_lvl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_lvl, r_out_rev, r_out_speed};

    // divider is only kicked with a nonzero divisor while it is free
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVGO) |-> (!div_sts.busy && r_rate != '0))
        else $error("divider started while busy or with zero rate");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside of wait state");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted transaction not taken into execution");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not registered on completion");

endmodule

@@ tb/tb_top.sv @@
typedef struct packed {
    logic [smr_pkg::SPEED_W-1:0] speed;
    logic                        rev;
    logic [smr_pkg::LEVEL_W-1:0] level;
} t_drive_out;

class speed_ramp_tracker;
    logic [smr_pkg::RATE_W-1:0] accel_us;
    logic [smr_pkg::RATE_W-1:0] decel_us;
    int                         goal_step;
    int                         cur_step;
    logic [smr_pkg::TIME_W-1:0] elapsed_acc;
    logic [smr_pkg::TIME_W-1:0] last_stamp;
    t_drive_out                 due_q[$];
    int                         mismatches;

    function new();
        accel_us    = '0;
        decel_us    = '0;
        goal_step   = 1;
        cur_step    = 1;
        elapsed_acc = '0;
        last_stamp  = '0;
        mismatches  = 0;
    endfunction

    function void set_rates(logic [smr_pkg::RATE_W-1:0] accel,
                            logic [smr_pkg::RATE_W-1:0] decel);
        accel_us = accel;
        decel_us = decel;
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    // Move the current speed toward the goal by the whole steps that the
    // elapsed time buys at the active rate.
    function void ramp_on_tick(logic [smr_pkg::TIME_W-1:0] now);
        logic [smr_pkg::TIME_W-1:0] delta;
        logic [smr_pkg::TIME_W-1:0] rate;
        logic [smr_pkg::TIME_W-1:0] quot;
        int                         steps;
        delta      = now - last_stamp;
        last_stamp = now;
        if (goal_step == cur_step) begin
            elapsed_acc = '0;
            return;
        end
        // away from stop uses accel, toward stop uses decel
        if (cur_step > goal_step)
            rate = (cur_step < 0) ? {8'd0, accel_us} : {8'd0, decel_us};
        else
            rate = (cur_step > 0) ? {8'd0, accel_us} : {8'd0, decel_us};
        if (rate == '0) begin
            if (cur_step < -1 && goal_step > -1)
                cur_step = 1;
            else if (cur_step > 1 && goal_step < 1)
                cur_step = -1;
            else
                cur_step = goal_step;
            return;
        end
        if (elapsed_acc > smr_pkg::TIME_MAX - delta)
            elapsed_acc = smr_pkg::TIME_MAX;
        else
            elapsed_acc = elapsed_acc + delta;
        quot = elapsed_acc / rate;
        if (quot == '0)
            return;
        steps       = (quot > 255) ? 255 : int'(quot);
        elapsed_acc = '0;
        // snap to the opposite stop when the move crosses zero
        if (goal_step > cur_step) begin
            if (cur_step < 0 && cur_step + steps >= 0)
                cur_step = 1;
            else if (cur_step + steps >= goal_step)
                cur_step = goal_step;
            else
                cur_step = cur_step + steps;
        end else begin
            if (cur_step > 0 && cur_step - steps <= 0)
                cur_step = -1;
            else if (cur_step - steps <= goal_step)
                cur_step = goal_step;
            else
                cur_step = cur_step - steps;
        end
    endfunction

    function void note_item(logic [smr_pkg::MODE_W-1:0] mode,
                            logic [smr_pkg::SPEED_W-1:0] sv_bits,
                            logic [smr_pkg::TIME_W-1:0] now,
                            logic [smr_pkg::LEVEL_W-1:0] fwd_lvl,
                            logic [smr_pkg::LEVEL_W-1:0] rev_lvl);
        int         sv;
        int         mag;
        int         scaled;
        t_drive_out want;
        sv = $signed(sv_bits);
        case (mode)
            smr_pkg::MODE_TICK: begin
                ramp_on_tick(now);
            end
            smr_pkg::MODE_GOAL128: begin
                goal_step = sv;
            end
            smr_pkg::MODE_GOAL28: begin
                mag = (sv < 0) ? -sv : sv;
                if (mag == 0)
                    mag = 1;
                scaled = ((mag - 1) * 9) >>> 1;
                if (scaled > 127)
                    scaled = 127;
                goal_step = (sv < 0) ? -scaled : scaled;
            end
            default: begin
                goal_step = (sv >= 0) ? 1 : -1;
                cur_step  = goal_step;
            end
        endcase
        want.speed = cur_step[smr_pkg::SPEED_W-1:0];
        want.rev   = (cur_step < 0);
        want.level = want.rev ? rev_lvl : fwd_lvl;
        due_q.push_back(want);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    task check_result(logic [23:0] data);
        t_drive_out want;
        if (due_q.size() == 0) begin
            report_mismatch("unexpected result, speed", $signed(data[7:0]), 0);
            return;
        end
        want = due_q.pop_front();
        if (data[7:0] !== want.speed)
            report_mismatch("current_speed", $signed(data[7:0]), $signed(want.speed));
        if (data[8] !== want.rev)
            report_mismatch("reverse", data[8], want.rev);
        if (data[16:9] !== want.level)
            report_mismatch("drive_level", data[16:9], want.level);
    endtask
endclass

module tb_top;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int ITEMS_PER_STEP = 205;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic [55:0]                 s_tdata = '0;
    logic [smr_pkg::MODE_W-1:0]  s_tuser = smr_pkg::MODE_TICK;
    logic                        m_tready = 1'b0;
    logic                        cfg_we = 1'b0;
    logic                        cfg_addr = smr_pkg::CFG_ACCEL;
    logic [smr_pkg::RATE_W-1:0]  cfg_wdata = '0;
    logic                        s_axis_tready;
    logic                        m_axis_tvalid;
    logic [23:0]                 m_axis_tdata;

    speed_ramp_tracker           tracker = new();
    int                          idle_mode = 0;
    int                          cycle_count = 0;
    logic [smr_pkg::TIME_W-1:0]  stamp_us = '0;

    speed_momentum_ramp u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        // [7:0] speed_value, [39:8] now_us, [47:40] forward_level,
        // [55:48] reverse_level
        .s_axis_tdata  (s_tdata),
        // [1:0] mode
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        // [7:0] current_speed, [8] reverse, [16:9] drive_level
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // signals are stable mid-cycle: a handshake seen here completes at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready)
            tracker.check_result(m_axis_tdata);
    end

    // pick the stall for the next cycle
    always @(posedge i_clk) begin
        int stall_pct;
        stall_pct = (idle_mode == 0) ? 74 : (idle_mode == 1) ? 11 : 0;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input logic [smr_pkg::MODE_W-1:0] mode,
                             input logic [smr_pkg::SPEED_W-1:0] sv,
                             input logic [smr_pkg::TIME_W-1:0] now,
                             input logic [smr_pkg::LEVEL_W-1:0] fwd_lvl,
                             input logic [smr_pkg::LEVEL_W-1:0] rev_lvl);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 11 : (idle_mode == 1) ? 74 : 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rev_lvl, fwd_lvl, now, sv};
        s_tuser  <= mode;
        // sample ready between edges, then take the accepting edge
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        tracker.note_item(mode, sv, now, fwd_lvl, rev_lvl);
    endtask

    task automatic send_tick(input logic [smr_pkg::TIME_W-1:0] now);
        stamp_us = now;
        send_item(smr_pkg::MODE_TICK, 8'($urandom), now, 8'($urandom), 8'($urandom));
    endtask

    // drop valid and hold until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_rates(input logic [smr_pkg::RATE_W-1:0] accel,
                               input logic [smr_pkg::RATE_W-1:0] decel);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= smr_pkg::CFG_ACCEL;
        cfg_wdata <= accel;
        @(posedge i_clk);
        cfg_addr  <= smr_pkg::CFG_DECEL;
        cfg_wdata <= decel;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        tracker.set_rates(accel, decel);
    endtask

    task automatic random_item(input logic [smr_pkg::RATE_W-1:0] rate_hint);
        int                         pick;
        logic [smr_pkg::TIME_W-1:0] delta;
        pick = $urandom_range(0, 99);
        if (pick < 76) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: delta = $urandom_range(0, 3 * rate_hint);
                6, 7:             delta = $urandom_range(0, 255);
                8:                delta = $urandom;
                default:          delta = '0;
            endcase
            send_tick(stamp_us + delta);
        end else if (pick < 88) begin
            send_item(smr_pkg::MODE_GOAL128, 8'($urandom), $urandom,
                      8'($urandom), 8'($urandom));
        end else if (pick < 97) begin
            send_item(smr_pkg::MODE_GOAL28, 8'($urandom), $urandom,
                      8'($urandom), 8'($urandom));
        end else begin
            send_item(smr_pkg::MODE_ESTOP, 8'($urandom), $urandom,
                      8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [smr_pkg::RATE_W-1:0] accel_sel;
        logic [smr_pkg::RATE_W-1:0] decel_sel;
        logic [smr_pkg::RATE_W-1:0] hint;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rates are zero after reset: every move is instant
        send_tick(32'd100);
        send_item(smr_pkg::MODE_GOAL128, 8'sd127, $urandom, 8'hFF, 8'h00);
        send_tick(32'd200);
        send_item(smr_pkg::MODE_GOAL128, -8'sd127, $urandom, 8'h00, 8'hFF);
        send_tick(32'd300);
        send_tick(32'd400);
        send_item(smr_pkg::MODE_GOAL128, 8'h80, $urandom, 8'hFF, 8'h00);
        send_tick(32'd500);
        send_item(smr_pkg::MODE_GOAL128, 8'd0, $urandom, 8'h00, 8'hFF);
        send_tick(32'd600);
        send_tick(32'd700);
        // 28-step goals: zero magnitude, one, smallest move, saturation
        send_item(smr_pkg::MODE_GOAL28, 8'd0, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_GOAL28, 8'd1, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_GOAL28, 8'd2, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_GOAL28, -8'sd29, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_GOAL28, 8'd30, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_GOAL28, 8'd127, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_GOAL28, 8'h80, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_ESTOP, 8'd5, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_ESTOP, 8'hFF, $urandom, 8'($urandom), 8'($urandom));
        send_item(smr_pkg::MODE_ESTOP, 8'd0, $urandom, 8'($urandom), 8'($urandom));

        // partial step, then a wrapped delta that saturates the accumulator
        write_rates(24'd1000, 24'hFF_FFFF);
        send_item(smr_pkg::MODE_GOAL128, 8'd50, $urandom, 8'($urandom), 8'($urandom));
        send_tick(stamp_us + 32'd500);
        send_tick(stamp_us - 32'd1);
        send_tick(stamp_us + 32'd7);

        for (int step = 0; step < 9; step++) begin
            idle_mode = step / 3;
            case (step)
                0:       begin accel_sel = 24'd1;       decel_sel = 24'd1;       end
                1:       begin accel_sel = 24'd0;       decel_sel = 24'd37;      end
                2:       begin accel_sel = 24'd250;     decel_sel = 24'd0;       end
                3:       begin accel_sel = 24'hFF_FFFF; decel_sel = 24'hFF_FFFF; end
                4:       begin accel_sel = 24'd3000;    decel_sel = 24'd700;     end
                5: begin
                    accel_sel = 24'($urandom);
                    decel_sel = 24'($urandom);
                end
                6:       begin accel_sel = 24'hFF_FFFF; decel_sel = 24'd1;       end
                7: begin
                    accel_sel = 24'($urandom_range(0, 4000));
                    decel_sel = 24'($urandom_range(0, 4000));
                end
                default: begin accel_sel = 24'd0;       decel_sel = 24'd0;       end
            endcase
            write_rates(accel_sel, decel_sel);
            hint = (accel_sel > decel_sel) ? accel_sel : decel_sel;
            if (hint == '0)
                hint = 24'd100;
            repeat (ITEMS_PER_STEP) random_item(hint);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
